// ===== design/ising_pkg.sv =====
package ising_pkg;

  // Item command codes.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_GAIN4 = 1'b0;
  localparam logic CFG_GAIN8 = 1'b1;

  // Acceptance limits after reset, given as fractions of 2^LIMIT_BASE_BITS.
  localparam int LIMIT_BASE_BITS = 16;
  localparam longint LIMIT4_BASE = 29446;
  localparam longint LIMIT8_BASE = 13231;

endpackage

// ===== design/ising_ram.sv =====
module ising_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port; read data holds while idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/ising_metropolis_spin_update_top.sv =====
// Channel  | Direction | Handshake                | Beat contents
// input    | in        | in_valid_i / in_ready_o  | command, row, col, random fraction, spin
// output   | out       | out_valid_o / out_ready_i| flipped, new spin, dE, magnetization, energy
// config   | in        | cfg_we_i (no wait)       | register index, write data
//
// An item's result is registered in ST_CALC after ST_RD_UP and ST_RD_DN: the lattice sits in one
// row-wide memory with a single read port, and the center, upper and lower rows are
// read one after another before the modified center row is written back.
// The next item can be accepted in the cycle after that write, so items never overlap.
// After reset a clearing pass writes every row to all +1 spins;
// no item is accepted during it, configuration writes are taken throughout.
// A result that is not taken holds the block in its last step until the output frees.
module ising_metropolis_spin_update_top #(
  parameter int SIDE = 64,
  parameter int FRACTION_BITS = 16,
  localparam int IDX_W = $clog2(SIDE),
  localparam int SITES = SIDE * SIDE,
  localparam int MAG_W = $clog2(SITES + 1) + 1,
  localparam int ENERGY_W = $clog2(4 * SITES + 1) + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [FRACTION_BITS-1:0]   cfg_data_i,
  // Input channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [IDX_W-1:0]           row_i,
  input  logic [IDX_W-1:0]           col_i,
  input  logic [FRACTION_BITS-1:0]   random_fraction_i,
  input  logic                       spin_value_i,
  // Output channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       flipped_o,
  output logic                       new_spin_o,
  output logic signed [4:0]          site_energy_delta_o,
  output logic signed [MAG_W-1:0]    magnetization_o,
  output logic signed [ENERGY_W-1:0] total_energy_o
);

  localparam int UP_SHIFT = (FRACTION_BITS >= ising_pkg::LIMIT_BASE_BITS) ?
                            FRACTION_BITS - ising_pkg::LIMIT_BASE_BITS : 0;
  localparam int DN_SHIFT = (FRACTION_BITS < ising_pkg::LIMIT_BASE_BITS) ?
                            ising_pkg::LIMIT_BASE_BITS - FRACTION_BITS : 0;
  localparam logic [FRACTION_BITS-1:0] LIMIT4_RST =
    FRACTION_BITS'((ising_pkg::LIMIT4_BASE << UP_SHIFT) >> DN_SHIFT);
  localparam logic [FRACTION_BITS-1:0] LIMIT8_RST =
    FRACTION_BITS'((ising_pkg::LIMIT8_BASE << UP_SHIFT) >> DN_SHIFT);
  localparam logic signed [MAG_W-1:0] MAG_RST = MAG_W'(SITES);
  localparam logic signed [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-4 * SITES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIDE - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RD_UP = 5'b00100,
    ST_RD_DN = 5'b01000,
    ST_CALC  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  logic [FRACTION_BITS-1:0] limit4_q, limit8_q;

  // Item registers.
  logic                     cmd_q, cmd_d;
  logic [IDX_W-1:0]         row_q, row_d;
  logic [IDX_W-1:0]         col_q, col_d;
  logic [IDX_W-1:0]         colp_q, colp_d;
  logic [IDX_W-1:0]         colm_q, colm_d;
  logic [FRACTION_BITS-1:0] rnd_q, rnd_d;
  logic                     val_q, val_d;
  logic [SIDE-1:0]          center_q, center_d;
  logic [SIDE-1:0]          up_q, up_d;

  // Running sums.
  logic signed [MAG_W-1:0]    mag_q, mag_d;
  logic signed [ENERGY_W-1:0] energy_q, energy_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic                       flipped_q, flipped_d;
  logic                       new_spin_q, new_spin_d;
  logic signed [4:0]          de_q, de_d;

  // Memory port signals.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [SIDE-1:0]  ram_wdata, ram_rdata;

  // Datapath signals of the final step.
  logic [IDX_W:0]   row_ext, col_ext;
  logic [IDX_W-1:0] row_mod, col_mod, row_up, row_dn;
  logic             s_old, flip, new_spin, fire;
  logic [2:0]       n_up;
  logic [4:0]       four_n, de_pos;
  logic signed [4:0] de;
  logic [SIDE-1:0]  new_row;

  ising_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_lattice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Site indexes wrap into the lattice; the input range stays below twice the side.
  always_comb begin
    row_ext = {1'b0, row_i};
    col_ext = {1'b0, col_i};
    row_mod = (row_ext >= (IDX_W + 1)'(SIDE)) ? IDX_W'(row_ext - (IDX_W + 1)'(SIDE)) : row_i;
    col_mod = (col_ext >= (IDX_W + 1)'(SIDE)) ? IDX_W'(col_ext - (IDX_W + 1)'(SIDE)) : col_i;
    row_up  = (row_q == '0) ? LAST_IDX : row_q - 1'b1;
    row_dn  = (row_q == LAST_IDX) ? '0 : row_q + 1'b1;
  end

  // Energy change and acceptance decision from the three rows now at hand.
  always_comb begin
    s_old  = center_q[col_q];
    n_up   = 3'(up_q[col_q]) + 3'(ram_rdata[col_q]) + 3'(center_q[colp_q])
           + 3'(center_q[colm_q]);
    four_n = {n_up, 2'b00};
    de_pos = four_n - 5'd8;
    de     = s_old ? de_pos : -de_pos;
    if (cmd_q == ising_pkg::CMD_WRITE) begin
      flip = (val_q != s_old);
    end else if (de[4] || de == 5'sd0) begin
      flip = 1'b1;
    end else if (de == 5'sd4) begin
      flip = rnd_q < limit4_q;
    end else begin
      flip = rnd_q < limit8_q;
    end
    new_spin = s_old ^ flip;
    new_row = center_q;
    new_row[col_q] = new_spin;
  end

  assign fire = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: clearing pass, three row reads, then write back and result.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    colp_d      = colp_q;
    colm_d      = colm_q;
    rnd_d       = rnd_q;
    val_d       = val_q;
    center_d    = center_q;
    up_d        = up_q;
    mag_d       = mag_q;
    energy_d    = energy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    flipped_d   = flipped_q;
    new_spin_d  = new_spin_q;
    de_d        = de_q;
    ram_we      = 1'b0;
    ram_waddr   = row_q;
    ram_wdata   = new_row;
    ram_re      = 1'b0;
    ram_raddr   = row_mod;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_re  = 1'b1;
          cmd_d   = command_i;
          row_d   = row_mod;
          col_d   = col_mod;
          colp_d  = (col_mod == LAST_IDX) ? '0 : col_mod + 1'b1;
          colm_d  = (col_mod == '0) ? LAST_IDX : col_mod - 1'b1;
          rnd_d   = random_fraction_i;
          val_d   = spin_value_i;
          state_d = ST_RD_UP;
        end
      end
      ST_RD_UP: begin
        center_d  = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = row_up;
        state_d   = ST_RD_DN;
      end
      ST_RD_DN: begin
        up_d      = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = row_dn;
        state_d   = ST_CALC;
      end
      ST_CALC: begin
        if (fire) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          flipped_d   = flip;
          new_spin_d  = new_spin;
          de_d        = de;
          if (flip) begin
            mag_d    = s_old ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2);
            energy_d = energy_q + ENERGY_W'({{(ENERGY_W - 6){de[4]}}, de, 1'b0});
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control and sum registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mag_q       <= MAG_RST;
      energy_q    <= ENERGY_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      mag_q       <= mag_d;
      energy_q    <= energy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Acceptance limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit4_q <= LIMIT4_RST;
      limit8_q <= LIMIT8_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ising_pkg::CFG_GAIN4: limit4_q <= cfg_data_i;
        ising_pkg::CFG_GAIN8: limit8_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    row_q      <= row_d;
    col_q      <= col_d;
    colp_q     <= colp_d;
    colm_q     <= colm_d;
    rnd_q      <= rnd_d;
    val_q      <= val_d;
    center_q   <= center_d;
    up_q       <= up_d;
    flipped_q  <= flipped_d;
    new_spin_q <= new_spin_d;
    de_q       <= de_d;
  end

  assign out_valid_o         = out_valid_q;
  assign flipped_o           = flipped_q;
  assign new_spin_o          = new_spin_q;
  assign site_energy_delta_o = de_q;
  assign magnetization_o     = mag_q;
  assign total_energy_o      = energy_q;

endmodule

// ===== design/ising_checker.sv =====
module ising_checker #(
  parameter int SIDE = 64,
  localparam int SITES = SIDE * SIDE,
  localparam int MAG_W = $clog2(SITES + 1) + 1,
  localparam int ENERGY_W = $clog2(4 * SITES + 1) + 1
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       flipped_o,
  input logic                       new_spin_o,
  input logic signed [4:0]          site_energy_delta_o,
  input logic signed [MAG_W-1:0]    magnetization_o,
  input logic signed [ENERGY_W-1:0] total_energy_o
);

  // A result that is not taken stays with the same contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(flipped_o) &&
      $stable(new_spin_o) && $stable(site_energy_delta_o) &&
      $stable(magnetization_o) && $stable(total_energy_o))
    else $error("stalled result changed");

  // Only one item is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // The local energy change is one of the five values a square lattice allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> site_energy_delta_o == -5'sd8 || site_energy_delta_o == -5'sd4 ||
      site_energy_delta_o == 5'sd0 || site_energy_delta_o == 5'sd4 ||
      site_energy_delta_o == 5'sd8)
    else $error("energy change out of range");

  // Every bond is counted twice, so the total energy stays a multiple of four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_energy_o[1:0] == 2'b00)
    else $error("total energy not a multiple of four");

endmodule

bind ising_metropolis_spin_update_top ising_checker #(
  .SIDE (SIDE)
) u_ising_checker (.*);

// ===== bench/ising_metropolis_spin_update_top_test.sv =====
module ising_metropolis_spin_update_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATTICE_SIDE  = 64;
  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_BEATS   = 126;
  localparam int DRILL_ROWS    = 17;

  typedef struct packed {
    logic        command;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] rnd;
    logic        spin;
  } spin_item_t;

  typedef struct packed {
    logic               flipped;
    logic               new_spin;
    logic signed [4:0]  delta;
    logic signed [13:0] mag;
    logic signed [15:0] energy;
  } spin_result_t;

  // One row of the directed part; the outcome is used only where given is set.
  typedef struct packed {
    spin_item_t   item;
    logic         given;
    spin_result_t outcome;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic command_i;
  logic [5:0] row_i;
  logic [5:0] col_i;
  logic [15:0] random_fraction_i;
  logic spin_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic flipped_o;
  logic new_spin_o;
  logic signed [4:0] site_energy_delta_o;
  logic signed [13:0] magnetization_o;
  logic signed [15:0] total_energy_o;

  // Predictor state: spins (1 = +1), running sums and acceptance limits.
  bit          model_spins [LATTICE_SIDE][LATTICE_SIDE];
  int          model_mag;
  int          model_energy;
  logic [15:0] model_limit4;
  logic [15:0] model_limit8;

  spin_result_t pending_outcomes [$];
  drill_row_t   drill [DRILL_ROWS];
  int           mismatches = 0;
  logic         hold_start;
  logic         hold_taken;

  ising_metropolis_spin_update_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .row_i              (row_i),
    .col_i              (col_i),
    .random_fraction_i  (random_fraction_i),
    .spin_value_i       (spin_value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .flipped_o          (flipped_o),
    .new_spin_o         (new_spin_o),
    .site_energy_delta_o(site_energy_delta_o),
    .magnetization_o    (magnetization_o),
    .total_energy_o     (total_energy_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int spin_sign(logic [5:0] r, logic [5:0] c);
    return model_spins[r][c] ? 1 : -1;
  endfunction

  // Metropolis decision for one beat; updates the lattice and both sums.
  function automatic spin_result_t metropolis_step(spin_item_t it);
    int s;
    int nsum;
    int de;
    bit flip;
    spin_result_t res;
    s = spin_sign(it.row, it.col);
    // Six-bit indexes wrap around the periodic boundary by themselves.
    nsum = spin_sign(it.row + 6'd1, it.col) + spin_sign(it.row - 6'd1, it.col)
         + spin_sign(it.row, it.col + 6'd1) + spin_sign(it.row, it.col - 6'd1);
    de = 2 * s * nsum;
    if (it.command == ising_pkg::CMD_WRITE) begin
      flip = (it.spin != model_spins[it.row][it.col]);
    end else if (de <= 0) begin
      flip = 1'b1;
    end else if (de == 4) begin
      flip = it.rnd < model_limit4;
    end else begin
      flip = it.rnd < model_limit8;
    end
    if (flip) begin
      model_spins[it.row][it.col] = ~model_spins[it.row][it.col];
      model_mag += -2 * s;
      model_energy += 2 * de;
    end
    res.flipped  = flip;
    res.new_spin = model_spins[it.row][it.col];
    res.delta    = 5'(de);
    res.mag      = 14'(model_mag);
    res.energy   = 16'(model_energy);
    return res;
  endfunction

  // Random beat: mostly updates, a share of writes, and half of all beats clustered
  // around the corner so neighbours interact and the wrap is crossed often.
  function automatic spin_item_t draw_item();
    spin_item_t it;
    it.command = ($urandom_range(0, 4) == 0) ? ising_pkg::CMD_WRITE : ising_pkg::CMD_UPDATE;
    if ($urandom_range(0, 1) == 1) begin
      it.row = 6'($urandom_range(0, 3)) - 6'd2;
      it.col = 6'($urandom_range(0, 3)) - 6'd2;
    end else begin
      it.row = 6'($urandom);
      it.col = 6'($urandom);
    end
    case ($urandom_range(0, 3))
      0: it.rnd = model_limit4 + 16'($urandom_range(0, 2)) - 16'd1;
      1: it.rnd = model_limit8 + 16'($urandom_range(0, 2)) - 16'd1;
      default: it.rnd = 16'($urandom);
    endcase
    it.spin = 1'($urandom);
    return it;
  endfunction

  // Offer one beat and hold it until accepted, then record its outcome.
  task automatic send_item(input spin_item_t it, input logic given,
                           input spin_result_t stated);
    spin_result_t predicted;
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    command_i         <= it.command;
    row_i             <= it.row;
    col_i             <= it.col;
    random_fraction_i <= it.rnd;
    spin_value_i      <= it.spin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = metropolis_step(it);
    pending_outcomes.push_back(given ? stated : predicted);
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic write_limit(input logic idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ising_pkg::CFG_GAIN4) begin
      model_limit4 = value;
    end else begin
      model_limit8 = value;
    end
  endtask

  task automatic settle_after_drain();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] expv,
                             input logic signed [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endtask

  // Result checker: every accepted result beat against the oldest outcome.
  always @(posedge clk_i) begin
    spin_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no outcome pending");
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("flipped", want.flipped, flipped_o);
        check_field("new_spin", want.new_spin, new_spin_o);
        check_field("site_energy_delta", want.delta, site_energy_delta_o);
        check_field("magnetization", want.mag, magnetization_o);
        check_field("total_energy", want.energy, total_energy_o);
      end
    end
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stall pattern that changes mode over time, plus one long hold.
  initial begin
    int unsigned cyc;
    int unsigned held;
    logic ready_next;
    out_ready_i = 1'b0;
    hold_taken  = 1'b0;
    cyc  = 0;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_start && !hold_taken) begin
        ready_next = 1'b0;
        held++;
        if (held >= HOLD_CYCLES) hold_taken = 1'b1;
      end else begin
        case ((cyc / 150) % 4)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          2: ready_next = ($urandom_range(0, 3) == 0);
          default: ready_next = (cyc % 7) < 4;
        endcase
      end
      out_ready_i <= ready_next;
      cyc++;
    end
  end

  // Stimulus: directed rows, then random phases under several limit settings.
  initial begin
    int phase;
    int sent;
    int burst;
    int k;
    logic [15:0] g4;
    logic [15:0] g8;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = ising_pkg::CFG_GAIN4;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    command_i         = ising_pkg::CMD_UPDATE;
    row_i             = '0;
    col_i             = '0;
    random_fraction_i = '0;
    spin_value_i      = 1'b0;
    hold_start        = 1'b0;

    // Predictor reset: all spins up, fully aligned energy.
    foreach (model_spins[r, c]) model_spins[r][c] = 1'b1;
    model_mag    = LATTICE_SIDE * LATTICE_SIDE;
    model_energy = -4 * LATTICE_SIDE * LATTICE_SIDE;
    model_limit4 = 16'(ising_pkg::LIMIT4_BASE);
    model_limit8 = 16'(ising_pkg::LIMIT8_BASE);

    // From the aligned lattice: dE of 8 at and around the threshold, a corner
    // site across both wraps, a zero change, writes that change and that
    // do not, a lowering move, and dE of 4 on both sides of its threshold.
    drill = '{
      '{'{ising_pkg::CMD_UPDATE, 6'd0,  6'd0,  16'hFFFF, 1'b0}, 1'b1,
        '{1'b0, 1'b1, 5'sd8, 14'sd4096, -16'sd16384}},
      '{'{ising_pkg::CMD_UPDATE, 6'd0,  6'd0,  16'd13231, 1'b0}, 1'b1,
        '{1'b0, 1'b1, 5'sd8, 14'sd4096, -16'sd16384}},
      '{'{ising_pkg::CMD_UPDATE, 6'd0,  6'd0,  16'd13230, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 5'sd8, 14'sd4094, -16'sd16368}},
      '{'{ising_pkg::CMD_UPDATE, 6'd63, 6'd63, 16'd0, 1'b1}, 1'b1,
        '{1'b1, 1'b0, 5'sd8, 14'sd4092, -16'sd16352}},
      '{'{ising_pkg::CMD_UPDATE, 6'd0,  6'd63, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_WRITE,  6'd0,  6'd1,  16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_WRITE,  6'd0,  6'd1,  16'd0, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_WRITE,  6'd10, 6'd10, 16'd12345, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_UPDATE, 6'd10, 6'd10, 16'hFFFF, 1'b1}, 1'b0, '0},
      '{'{ising_pkg::CMD_WRITE,  6'd20, 6'd20, 16'hAAAA, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_UPDATE, 6'd20, 6'd21, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_UPDATE, 6'd20, 6'd21, 16'd29446, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_UPDATE, 6'd20, 6'd21, 16'd29445, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_UPDATE, 6'd20, 6'd21, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{ising_pkg::CMD_WRITE,  6'd0,  6'd0,  16'h5555, 1'b1}, 1'b0, '0},
      '{'{ising_pkg::CMD_WRITE,  6'd63, 6'd63, 16'd0, 1'b1}, 1'b0, '0},
      '{'{ising_pkg::CMD_UPDATE, 6'd63, 6'd0,  16'd0, 1'b0}, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows go back to back; the clearing pass simply holds them off.
    for (k = 0; k < DRILL_ROWS; k++) begin
      send_item(drill[k].item, drill[k].given, drill[k].outcome);
    end
    idle_for(1);

    for (phase = 0; phase < 5; phase++) begin
      settle_after_drain();
      case (phase)
        1: begin g4 = 16'hFFFF; g8 = 16'hFFFF; end
        2: begin g4 = 16'h0000; g8 = 16'h0000; end
        3: begin g4 = 16'h0000; g8 = 16'hFFFF; end
        default: begin g4 = 16'($urandom); g8 = 16'($urandom); end
      endcase
      write_limit(ising_pkg::CFG_GAIN4, g4);
      write_limit(ising_pkg::CFG_GAIN8, g8);
      // Back the block up against a stopped receiver once.
      if (phase == 2) hold_start = 1'b1;

      // Bursts of random length with random gaps, some long and unbroken.
      sent = 0;
      while (sent < PHASE_BEATS) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (k = 0; k < burst && sent < PHASE_BEATS; k++) begin
          send_item(draw_item(), 1'b0, '0);
          sent++;
        end
        idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
      end
      idle_for(1);
    end

    settle_after_drain();
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
